// ----- design/vbm_pkg.sv -----
// Shared types and constants for the video bus mirror and video memory block.
package vbm_pkg;

  typedef enum logic [1:0] {
    KIND_WR_WORD = 2'd0,
    KIND_WR_BYTE = 2'd1,
    KIND_RD_WORD = 2'd2,
    KIND_RD_BYTE = 2'd3
  } kind_t;

  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd0;
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd1;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_MIRROR_MODE = 3'd0;

  // Video bus map
  localparam logic [15:0] NT_LOW_1    = 16'h2400;
  localparam logic [15:0] NT_HIGH_0   = 16'h2800;
  localparam logic [15:0] NT_HIGH_1   = 16'h2C00;
  localparam logic [15:0] FOLD_BASE   = 16'h3000;
  localparam logic [15:0] FOLD_OFFSET = 16'h1000;
  localparam logic [15:0] PAL_BASE    = 16'h3F00;
  localparam logic [15:0] PAL_END     = 16'h3F20;
  localparam logic [15:0] BUS_END     = 16'h4000;
  localparam logic [15:0] NT_SIZE     = 16'h0400;
  localparam logic [15:0] NT_PAIR     = 16'h0800;
  localparam logic [15:0] PHYS_PAL    = 16'h3000;

  typedef struct packed {
    logic [15:0] phys;
    logic        word;
    logic        write;
    logic        bad;
  } map_t;

endpackage

// ----- design/vbm_map.sv -----
// Address folding, name table mirroring and range check for one item.
module vbm_map #(
  parameter int unsigned STORE_BYTES = 12320
) (
  input  logic [1:0]   mirror_mode,
  input  logic [1:0]   kind,
  input  logic [15:0]  bus_address,
  output vbm_pkg::map_t map
);
  import vbm_pkg::*;

  logic [15:0] folded;
  logic [4:0]  low;
  logic [15:0] phys;
  logic [16:0] last;
  logic        word;

  always_comb begin
    low = bus_address[4:0];
    // palette entries 0x10/0x14/0x18/0x1C alias the background entries
    if (low[4] && low[1:0] == 2'b00) begin
      low[4] = 1'b0;
    end
    if (bus_address < FOLD_BASE) begin
      folded = bus_address;
    end else if (bus_address < PAL_BASE) begin
      folded = bus_address - FOLD_OFFSET;
    end else if (bus_address < BUS_END) begin
      folded = {PAL_BASE[15:5], low};
    end else begin
      folded = bus_address;
    end
  end

  always_comb begin
    phys = folded;
    if (folded < FOLD_BASE) begin
      case (mirror_mode)
        MIRROR_HORIZONTAL: begin
          if ((folded >= NT_LOW_1 && folded < NT_HIGH_0) ||
              (folded >= NT_HIGH_1 && folded < FOLD_BASE)) begin
            phys = folded - NT_SIZE;
          end
        end
        MIRROR_VERTICAL: begin
          if (folded >= NT_HIGH_0 && folded < FOLD_BASE) begin
            phys = folded - NT_PAIR;
          end
        end
        default: phys = folded;
      endcase
    end else if (folded < PAL_END) begin
      phys = {PHYS_PAL[15:5], folded[4:0]};
    end
  end

  assign word = (kind_t'(kind) == KIND_WR_WORD) || (kind_t'(kind) == KIND_RD_WORD);
  assign last = {1'b0, phys} + {16'd0, word};

  assign map.phys  = phys;
  assign map.word  = word;
  assign map.write = (kind_t'(kind) == KIND_WR_WORD) || (kind_t'(kind) == KIND_WR_BYTE);
  assign map.bad   = (last >= 17'(STORE_BYTES));

endmodule

// ----- design/vbm_vram.sv -----
// Byte store split into even and odd banks so a word touches each bank once.
module vbm_vram #(
  parameter int unsigned STORE_BYTES = 12320
) (
  input  logic          clk,
  input  logic          en,
  input  vbm_pkg::map_t map,
  input  logic [15:0]   write_data,
  output logic [15:0]   rd_data
);
  import vbm_pkg::*;

  localparam int unsigned BANK_DEPTH = (STORE_BYTES + 1) / 2;
  localparam int unsigned IW = $clog2(BANK_DEPTH);

  logic [7:0] even_bank [BANK_DEPTH];
  logic [7:0] odd_bank  [BANK_DEPTH];

  logic [16:0]   even_sum;
  logic [IW-1:0] even_idx;
  logic [IW-1:0] odd_idx;
  logic          odd_start;
  logic [7:0]    even_wdata;
  logic [7:0]    odd_wdata;
  logic          even_we;
  logic          odd_we;

  logic [7:0] even_q;
  logic [7:0] odd_q;
  logic       swap_q;
  logic       word_q;

  assign odd_start = map.phys[0];
  // an odd start pairs with the next even byte
  assign even_sum  = {1'b0, map.phys} + {16'd0, odd_start};
  assign even_idx  = even_sum[IW:1];
  assign odd_idx   = map.phys[IW:1];

  assign even_wdata = odd_start ? write_data[15:8] : write_data[7:0];
  assign odd_wdata  = odd_start ? write_data[7:0]  : write_data[15:8];
  assign even_we = en && map.write && (map.word || !odd_start);
  assign odd_we  = en && map.write && (map.word || odd_start);

  always_ff @(posedge clk) begin
    if (even_we) begin
      even_bank[even_idx] <= even_wdata;
    end
    even_q <= even_bank[even_idx];
  end

  always_ff @(posedge clk) begin
    if (odd_we) begin
      odd_bank[odd_idx] <= odd_wdata;
    end
    odd_q <= odd_bank[odd_idx];
  end

  always_ff @(posedge clk) begin
    swap_q <= odd_start;
    word_q <= map.word;
  end

  always_comb begin
    if (word_q) begin
      rd_data = swap_q ? {even_q, odd_q} : {odd_q, even_q};
    end else begin
      rd_data = {8'd0, swap_q ? odd_q : even_q};
    end
  end

endmodule

// ----- design/video_bus_mirror_and_vram.sv -----
// Top level of the video bus mirror and video memory block.
//
// Each item is one access to the video bus: a byte or little-endian word,
// read or written, at a 16-bit bus address. The address is folded onto the
// standard video map (name table mirror at 0x3000-0x3EFF, palette repeats
// and background aliases above 0x3F00), name tables fold by mirror_mode
// (0 horizontal, 1 vertical, 2 or 3 none), and the palette lands at physical
// 0x3000. An access whose last byte falls at or beyond STORE_BYTES is
// dropped and returns bad_access with read_data zero. Timing: an item is
// taken on any cycle with start high and busy low; busy is high only during
// reset, so a new item may enter every cycle. Its result appears on done in the
// next cycle, for a single cycle, and the receiver cannot stall it. The result
// is registered by the read of the byte store, which is two single-port banks
// (even and odd bytes) so a word at any alignment needs one access per bank.
// A read sees every write from earlier items. The store holds no defined
// data until written; there is no clearing pass.
module video_bus_mirror_and_vram #(
  parameter int unsigned STORE_BYTES = 12320
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vbm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // access items
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [15:0]                 bus_address,
  input  logic [15:0]                 write_data,
  output logic                        done,
  output logic [15:0]                 read_data,
  output logic                        bad_access
);
  import vbm_pkg::*;

  logic [1:0]  mirror_mode;
  logic        accept;
  map_t        map;
  logic [15:0] vram_data;
  logic        bad_q;
  logic        rd_q;

  assign pready = 1'b1;
  assign busy   = rst;
  assign accept = start && !busy;

  // configuration register; the user must write it only while no item is in flight (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_mode <= MIRROR_HORIZONTAL;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MIRROR_MODE) begin
      mirror_mode <= pwdata[1:0];
    end
  end

  assign prdata = (paddr == ADDR_MIRROR_MODE) ? {30'd0, mirror_mode} : 32'd0;

  vbm_map #(
    .STORE_BYTES(STORE_BYTES)
  ) u_map (
    .mirror_mode(mirror_mode),
    .kind       (kind),
    .bus_address(bus_address),
    .map        (map)
  );

  // drop the store access for out-of-range items
  vbm_vram #(
    .STORE_BYTES(STORE_BYTES)
  ) u_vram (
    .clk       (clk),
    .en        (accept && !map.bad),
    .map       (map),
    .write_data(write_data),
    .rd_data   (vram_data)
  );

  // result strobe and flags are registered in step with the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      bad_q <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      done  <= accept;
      bad_q <= accept && map.bad;
      rd_q  <= accept && !map.bad && !map.write;
    end
  end

  // writes and bad accesses return zero
  assign read_data  = rd_q ? vram_data : 16'd0;
  assign bad_access = bad_q;

endmodule

// ----- design/vbm_checker.sv -----
// Port-level checks for the video bus mirror and video memory block.
module vbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  kind,
  input logic        done,
  input logic [15:0] read_data,
  input logic        bad_access
);
  import vbm_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("accepted item gave no result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without an accepted item");

  a_bad_reads_zero: assert property (@(posedge clk) disable iff (rst)
    bad_access |-> done && read_data == 16'd0)
    else $error("bad access carries data or no strobe");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    done && ($past(kind) == KIND_WR_WORD || $past(kind) == KIND_WR_BYTE)
      |-> read_data == 16'd0)
    else $error("write returned nonzero data");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !done |-> !bad_access && read_data == 16'd0)
    else $error("result ports active without strobe");

endmodule

bind video_bus_mirror_and_vram vbm_checker u_vbm_checker (.*);
